[src/mbps_pkg.sv]
// Package for the Mandelbrot pixel shader: payload structs, sequencer states,
// register indexes and fixed-point constants. No dependencies.
`default_nettype none

package mbps_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int ITER_LIMIT    = 1024;

  localparam int POS_W  = 10;
  localparam int CNT_W  = 11;
  localparam int COL_W  = 21;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;
  localparam int MUL_W  = 33;
  localparam int Z_W    = 40;
  localparam int Q_W    = 16;
  localparam int QC_W   = $clog2(Q_W);
  localparam int N_W    = $clog2(ITER_LIMIT + 1);
  localparam int D_W    = $clog2(SCREEN_WIDTH + SCREEN_HEIGHT + 2048) + 1;

  localparam logic [31:0] PITCH_RST    = 32'd42949673;
  localparam logic [10:0] MAX_ITER_RST = 11'd100;
  localparam logic [7:0]  TINT_R_RST   = 8'd9;
  localparam logic [7:0]  TINT_G_RST   = 8'd15;
  localparam logic [7:0]  TINT_B_RST   = 8'd8;

  localparam logic signed [Z_W-1:0] ESC_BOUND     = Z_W'(64'd10 << 28);
  localparam logic signed [Z_W-1:0] ESC_BOUND_NEG = -ESC_BOUND;
  localparam logic [64:0]           ESC_SQ        = 65'd100 << 56;
  localparam logic signed [63:0]    SAT_MAX       = 64'sd2147483647;
  localparam logic signed [63:0]    SAT_MIN       = -64'sd2147483648;
  localparam logic [Q_W:0]          ONE_Q16       = (Q_W + 1)'(1) << Q_W;

  typedef struct packed {
    logic [POS_W-1:0] pixel_col;
    logic [POS_W-1:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] iter_count;
    logic [COL_W-1:0] red_out;
    logic [COL_W-1:0] green_out;
    logic [COL_W-1:0] blue_out;
  } pix_out_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_PITCH,
    CFG_SHIFT_RE,
    CFG_SHIFT_IM,
    CFG_MAX_ITER,
    CFG_TINT_R,
    CFG_TINT_G,
    CFG_TINT_B
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_SAT_IM,
    ST_STEP,
    ST_SQ_X,
    ST_SQ_Y,
    ST_XY,
    ST_DIV_INIT,
    ST_DIV,
    ST_UT,
    ST_TT,
    ST_UU,
    ST_P_RED,
    ST_C_RED,
    ST_P_GRN,
    ST_C_GRN,
    ST_P_BLU,
    ST_C_BLU
  } state_t;

endpackage

`default_nettype wire

[src/mandelbrot_pixel_shader_top.sv]
// Mandelbrot escape-time pixel shader: one pixel in, iteration count and colour out.
// Depends on mbps_pkg for payload structs, states and constants.
//
// A transaction is taken when start is high and busy is low. The pixel is mapped to
// the plane, z = z^2 + c is iterated, the count is normalized by a bit-serial divider
// and three colour polynomials are formed. The wide products share one 33x33
// multiplier and a small 40x8 multiplier applies the colour gain: each iteration forms
// the update and then three products in turn. out_valid pulses for one cycle in the
// cycle busy falls, and a new start is taken in that same cycle. The result on out_data
// is complete while out_valid is high and is held until a new transaction overwrites
// it; the receiver cannot stall it.
`default_nettype none

module mandelbrot_pixel_shader_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire mbps_pkg::pix_in_t           in_data,
  output logic                             out_valid,
  output mbps_pkg::pix_out_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [mbps_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [mbps_pkg::CFG_W-1:0]  cfg_data
);

  mbps_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [31:0]        pitch_r;
  logic signed [31:0] shift_re_r;
  logic signed [31:0] shift_im_r;
  logic [10:0]        max_iter_r;
  logic [7:0]         tint_r_r;
  logic [7:0]         tint_g_r;
  logic [7:0]         tint_b_r;

  logic [mbps_pkg::POS_W-1:0] col_r;
  logic [mbps_pkg::POS_W-1:0] row_r;
  logic signed [31:0]         cr_r;
  logic signed [31:0]         ci_r;
  logic signed [mbps_pkg::MUL_W-1:0] x_r;
  logic signed [mbps_pkg::MUL_W-1:0] y_r;
  logic signed [63:0]         xx_r;
  logic signed [63:0]         yy_r;
  logic signed [63:0]         xy_r;
  logic [63:0]                p_r;
  logic [mbps_pkg::N_W-1:0]   n_r;
  logic [mbps_pkg::N_W-1:0]   m_r;
  logic [mbps_pkg::N_W-1:0]   rem_r;
  logic [mbps_pkg::Q_W-1:0]   q_r;
  logic [mbps_pkg::QC_W-1:0]  cnt_r;
  logic [mbps_pkg::COL_W-1:0] red_r;
  logic [mbps_pkg::COL_W-1:0] green_r;
  logic [mbps_pkg::COL_W-1:0] blue_r;

  logic signed [mbps_pkg::MUL_W-1:0]   mul_a;
  logic signed [mbps_pkg::MUL_W-1:0]   mul_b;
  logic signed [2*mbps_pkg::MUL_W-1:0] mul_p;
  logic signed [63:0]                  mul_q;

  logic signed [mbps_pkg::D_W-1:0] d_col;
  logic signed [mbps_pkg::D_W-1:0] d_row;
  logic signed [mbps_pkg::Z_W-1:0] nx;
  logic signed [mbps_pkg::Z_W-1:0] ny;
  logic                            esc_bound;
  logic                            esc_sq;
  logic [64:0]                     mag_sq;
  logic [mbps_pkg::N_W-1:0]        n_inc;
  logic [mbps_pkg::N_W-1:0]        m_eff;
  logic [mbps_pkg::N_W:0]          rem_sh;
  logic                            rem_ge;
  logic [mbps_pkg::Q_W:0]          t_w;
  logic [mbps_pkg::Q_W:0]          u_w;
  logic [7:0]                      tint_sel;
  logic [47:0]                     tint_p;
  logic                            accept;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > mbps_pkg::SAT_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < mbps_pkg::SAT_MIN) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  assign accept = start && (state_r == mbps_pkg::ST_IDLE);
  assign busy   = (state_r != mbps_pkg::ST_IDLE);

  assign d_col = $signed(mbps_pkg::D_W'({col_r, 1'b0}))
               - $signed(mbps_pkg::D_W'(mbps_pkg::SCREEN_WIDTH));
  assign d_row = $signed(mbps_pkg::D_W'({row_r, 1'b0}))
               - $signed(mbps_pkg::D_W'(mbps_pkg::SCREEN_HEIGHT));

  assign nx = mbps_pkg::Z_W'((xx_r - yy_r) >>> 28) + mbps_pkg::Z_W'(cr_r);
  assign ny = mbps_pkg::Z_W'(xy_r >>> 27) + mbps_pkg::Z_W'(ci_r);
  assign esc_bound = (nx > mbps_pkg::ESC_BOUND) || (nx < mbps_pkg::ESC_BOUND_NEG)
                  || (ny > mbps_pkg::ESC_BOUND) || (ny < mbps_pkg::ESC_BOUND_NEG);
  assign mag_sq = {1'b0, xx_r} + {1'b0, yy_r};
  assign esc_sq = (mag_sq > mbps_pkg::ESC_SQ);
  assign n_inc  = n_r + 1'b1;

  always_comb begin
    if (max_iter_r == 11'd0) begin
      m_eff = mbps_pkg::N_W'(1);
    end else if (32'(max_iter_r) > mbps_pkg::ITER_LIMIT) begin
      m_eff = mbps_pkg::N_W'(mbps_pkg::ITER_LIMIT);
    end else begin
      m_eff = mbps_pkg::N_W'(max_iter_r);
    end
  end

  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, m_r});

  assign t_w = (n_r == m_r) ? mbps_pkg::ONE_Q16 : {1'b0, q_r};
  assign u_w = mbps_pkg::ONE_Q16 - t_w;

  // shared multiplier; operand pairs chosen by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      mbps_pkg::ST_MAP_RE: begin
        mul_a = mbps_pkg::MUL_W'(d_col);
        mul_b = $signed(mbps_pkg::MUL_W'(pitch_r));
      end
      mbps_pkg::ST_MAP_IM: begin
        mul_a = mbps_pkg::MUL_W'(d_row);
        mul_b = $signed(mbps_pkg::MUL_W'(pitch_r));
      end
      mbps_pkg::ST_SQ_X: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      mbps_pkg::ST_SQ_Y: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      mbps_pkg::ST_XY: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      mbps_pkg::ST_UT: begin
        mul_a = $signed(mbps_pkg::MUL_W'(u_w));
        mul_b = $signed(mbps_pkg::MUL_W'(t_w));
      end
      mbps_pkg::ST_TT: begin
        mul_a = $signed(mbps_pkg::MUL_W'(t_w));
        mul_b = $signed(mbps_pkg::MUL_W'(t_w));
      end
      mbps_pkg::ST_UU: begin
        mul_a = $signed(mbps_pkg::MUL_W'(u_w));
        mul_b = $signed(mbps_pkg::MUL_W'(u_w));
      end
      // a factor of 2^32 only occurs when its partner is zero
      mbps_pkg::ST_P_RED: begin
        mul_a = xx_r[mbps_pkg::MUL_W-1:0];
        mul_b = yy_r[mbps_pkg::MUL_W-1:0];
      end
      mbps_pkg::ST_P_GRN: begin
        mul_a = xy_r[mbps_pkg::MUL_W-1:0];
        mul_b = yy_r[mbps_pkg::MUL_W-1:0];
      end
      mbps_pkg::ST_P_BLU: begin
        mul_a = xy_r[mbps_pkg::MUL_W-1:0];
        mul_b = xx_r[mbps_pkg::MUL_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign mul_q = 64'(mul_p);

  always_comb begin
    case (state_r)
      mbps_pkg::ST_C_RED: tint_sel = tint_r_r;
      mbps_pkg::ST_C_GRN: tint_sel = tint_g_r;
      default:            tint_sel = tint_b_r;
    endcase
  end

  assign tint_p = 48'(p_r[63:24]) * 48'(tint_sel);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbps_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = mbps_pkg::ST_MAP_RE;
        end
      end
      mbps_pkg::ST_MAP_RE: state_nxt = mbps_pkg::ST_MAP_IM;
      mbps_pkg::ST_MAP_IM: state_nxt = mbps_pkg::ST_SAT_IM;
      mbps_pkg::ST_SAT_IM: state_nxt = mbps_pkg::ST_STEP;
      mbps_pkg::ST_STEP: begin
        state_nxt = esc_bound ? mbps_pkg::ST_DIV_INIT : mbps_pkg::ST_SQ_X;
      end
      mbps_pkg::ST_SQ_X: state_nxt = mbps_pkg::ST_SQ_Y;
      mbps_pkg::ST_SQ_Y: state_nxt = mbps_pkg::ST_XY;
      mbps_pkg::ST_XY: begin
        if (esc_sq || (n_inc == m_r)) begin
          state_nxt = mbps_pkg::ST_DIV_INIT;
        end else begin
          state_nxt = mbps_pkg::ST_STEP;
        end
      end
      mbps_pkg::ST_DIV_INIT: state_nxt = mbps_pkg::ST_DIV;
      mbps_pkg::ST_DIV: begin
        if (cnt_r == mbps_pkg::QC_W'(mbps_pkg::Q_W - 1)) begin
          state_nxt = mbps_pkg::ST_UT;
        end
      end
      mbps_pkg::ST_UT:    state_nxt = mbps_pkg::ST_TT;
      mbps_pkg::ST_TT:    state_nxt = mbps_pkg::ST_UU;
      mbps_pkg::ST_UU:    state_nxt = mbps_pkg::ST_P_RED;
      mbps_pkg::ST_P_RED: state_nxt = mbps_pkg::ST_C_RED;
      mbps_pkg::ST_C_RED: state_nxt = mbps_pkg::ST_P_GRN;
      mbps_pkg::ST_P_GRN: state_nxt = mbps_pkg::ST_C_GRN;
      mbps_pkg::ST_C_GRN: state_nxt = mbps_pkg::ST_P_BLU;
      mbps_pkg::ST_P_BLU: state_nxt = mbps_pkg::ST_C_BLU;
      mbps_pkg::ST_C_BLU: state_nxt = mbps_pkg::ST_IDLE;
      default:            state_nxt = mbps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = (state_r == mbps_pkg::ST_C_BLU);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r    <= mbps_pkg::PITCH_RST;
      shift_re_r <= '0;
      shift_im_r <= '0;
      max_iter_r <= mbps_pkg::MAX_ITER_RST;
      tint_r_r   <= mbps_pkg::TINT_R_RST;
      tint_g_r   <= mbps_pkg::TINT_G_RST;
      tint_b_r   <= mbps_pkg::TINT_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbps_pkg::CFG_PITCH:    pitch_r    <= cfg_data;
        mbps_pkg::CFG_SHIFT_RE: shift_re_r <= $signed(cfg_data);
        mbps_pkg::CFG_SHIFT_IM: shift_im_r <= $signed(cfg_data);
        mbps_pkg::CFG_MAX_ITER: max_iter_r <= cfg_data[10:0];
        mbps_pkg::CFG_TINT_R:   tint_r_r   <= cfg_data[7:0];
        mbps_pkg::CFG_TINT_G:   tint_g_r   <= cfg_data[7:0];
        mbps_pkg::CFG_TINT_B:   tint_b_r   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mbps_pkg::ST_IDLE: begin
        if (accept) begin
          col_r <= in_data.pixel_col;
          row_r <= in_data.pixel_row;
          m_r   <= m_eff;
        end
      end
      mbps_pkg::ST_MAP_RE: xy_r <= mul_q;
      mbps_pkg::ST_MAP_IM: begin
        xy_r <= mul_q;
        cr_r <= sat32((xy_r >>> 5) - 64'(shift_re_r));
      end
      mbps_pkg::ST_SAT_IM: begin
        ci_r <= sat32((xy_r >>> 5) - 64'(shift_im_r));
        xx_r <= '0;
        yy_r <= '0;
        xy_r <= '0;
        n_r  <= '0;
      end
      mbps_pkg::ST_STEP: begin
        x_r <= mbps_pkg::MUL_W'(nx);
        y_r <= mbps_pkg::MUL_W'(ny);
      end
      mbps_pkg::ST_SQ_X: xx_r <= mul_q;
      mbps_pkg::ST_SQ_Y: yy_r <= mul_q;
      mbps_pkg::ST_XY: begin
        xy_r <= mul_q;
        if (!esc_sq) begin
          n_r <= n_inc;
        end
      end
      mbps_pkg::ST_DIV_INIT: begin
        rem_r <= n_r;
        q_r   <= '0;
        cnt_r <= '0;
      end
      mbps_pkg::ST_DIV: begin
        if (rem_ge) begin
          rem_r <= mbps_pkg::N_W'(rem_sh - {1'b0, m_r});
        end else begin
          rem_r <= mbps_pkg::N_W'(rem_sh);
        end
        q_r   <= {q_r[mbps_pkg::Q_W-2:0], rem_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      mbps_pkg::ST_UT:    xx_r    <= mul_q;
      mbps_pkg::ST_TT:    yy_r    <= mul_q;
      mbps_pkg::ST_UU:    xy_r    <= mul_q;
      mbps_pkg::ST_P_RED: p_r     <= mul_q;
      mbps_pkg::ST_C_RED: red_r   <= tint_p[44:24];
      mbps_pkg::ST_P_GRN: p_r     <= mul_q;
      mbps_pkg::ST_C_GRN: green_r <= tint_p[44:24];
      mbps_pkg::ST_P_BLU: p_r     <= mul_q;
      mbps_pkg::ST_C_BLU: blue_r  <= tint_p[44:24];
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = '{iter_count: mbps_pkg::CNT_W'(n_r),
                       red_out:    red_r,
                       green_out:  green_r,
                       blue_out:   blue_r};

endmodule

`default_nettype wire
